/* src/btpc_pkg.sv */
// Shared types, constants and helpers for the barometric trim compensator.
// No dependencies; imported by every other file of the block.
`default_nettype none
package btpc_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned RawWidth   = 20;
    localparam int unsigned TrimWidth  = 48;
    localparam int unsigned NumTrimReg = 4;

    // trim register indexes
    localparam logic [1:0] REG_TEMP    = 2'd0;
    localparam logic [1:0] REG_PRESS_A = 2'd1;
    localparam logic [1:0] REG_PRESS_B = 2'd2;
    localparam logic [1:0] REG_PRESS_C = 2'd3;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } trim_t;

    // queued item: temperature differences already formed against T1
    typedef struct packed {
        logic [RawWidth-1:0] raw_pressure;
        logic [17:0]         ta;
        logic [16:0]         tb;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_TV1,
        OP_BB,
        OP_TV2,
        OP_S1,
        OP_V2A,
        OP_S2,
        OP_S3,
        OP_S4,
        OP_S5,
        OP_NUM,
        OP_W1A,
        OP_W1B,
        OP_W2
    } op_t;

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        return 64'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage
`default_nettype wire

/* src/baro_temp_pressure_compensator_core.sv */
// Barometric trim compensator top level: trim registers, front queue, back end.
// Each item takes 13 products on the shared multiplier and one divide on the 1-bit
// divider; when the pressure divisor is zero the divide and the remaining products
// are skipped. The back end takes one item at a time; four items queue at the input
// while the back end works. Reset (rst_n, async, low) clears the trim registers to
// zero and empties queue and output.
`default_nettype none
module baro_temp_pressure_compensator_core #(
    parameter int unsigned QUEUE_DEPTH = btpc_pkg::QueueDepth
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // temperature_centi[31:0], fine_temperature[63:32],
                                        // pressure_q24_8[95:64]
    output logic             m_tuser,   // divisor_zero
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);
    import btpc_pkg::*;

    logic [TrimWidth-1:0] trim_reg [NumTrimReg];
    trim_t                trim;
    item_t                head;
    logic                 head_valid, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumTrimReg; i++)
                trim_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEMP:    trim_reg[0] <= cfg_data;
                REG_PRESS_A: trim_reg[1] <= cfg_data;
                REG_PRESS_B: trim_reg[2] <= cfg_data;
                REG_PRESS_C: trim_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        trim.t1 = trim_reg[0][15:0];
        trim.t2 = trim_reg[0][31:16];
        trim.t3 = trim_reg[0][47:32];
        trim.p1 = trim_reg[1][15:0];
        trim.p2 = trim_reg[1][31:16];
        trim.p3 = trim_reg[1][47:32];
        trim.p4 = trim_reg[2][15:0];
        trim.p5 = trim_reg[2][31:16];
        trim.p6 = trim_reg[2][47:32];
        trim.p7 = trim_reg[3][15:0];
        trim.p8 = trim_reg[3][31:16];
        trim.p9 = trim_reg[3][47:32];
    end

    btpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .t1         (trim.t1),
        .head_valid (head_valid),
        .pop        (pop),
        .head       (head)
    );

    btpc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .trim       (trim),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

/* src/btpc_queue.sv */
// Front end: accepts raw items, forms the T1 differences, queues them.
// Depends on btpc_pkg.
`default_nettype none
module btpc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [39:0]           s_tdata,
    input  wire logic [15:0]           t1,
    output logic                       head_valid,
    input  wire logic                  pop,
    output btpc_pkg::item_t            head
);
    import btpc_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    item_t          mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg, count_next;
    item_t          item_in;
    logic           push;

    always_comb
    begin
        item_in.raw_pressure = s_tdata[39:20];
        item_in.ta = {1'b0, s_tdata[19:3]} - {1'b0, t1, 1'b0};
        item_in.tb = {1'b0, s_tdata[19:4]} - {1'b0, t1};
    end

    assign s_tready   = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= item_in;
    end

endmodule
`default_nettype wire

/* src/btpc_mul.sv */
// Shared 64x64 multiplier, low 64 bits, one 32x32 partial product a cycle.
// Depends on btpc_pkg.
`default_nettype none
module btpc_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      result
);
    import btpc_pkg::*;

    logic [63:0] a_reg, b_reg, pp_reg, acc_reg;
    logic [1:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [31:0] op_a, op_b;
    logic [63:0] prod, pp_next;

    assign op_a    = (cnt_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
    assign op_b    = (cnt_reg == 2'd1) ? b_reg[63:32] : b_reg[31:0];
    assign prod    = {32'd0, op_a} * {32'd0, op_b};
    // cross terms only reach the upper word
    assign pp_next = (cnt_reg == 2'd0) ? prod : {prod[31:0], 32'h0};
    assign done    = done_reg;
    assign result  = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 2'd3)
                pp_reg <= pp_next;
            if (cnt_reg != 2'd0)
                acc_reg <= acc_reg + pp_reg;
        end
    end

endmodule
`default_nettype wire

/* src/btpc_div.sv */
// Signed 64-bit divider, truncating, one quotient bit a cycle.
// Depends on btpc_pkg.
`default_nettype none
module btpc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [63:0] den,
    output logic             done,
    output logic [63:0]      quotient
);
    import btpc_pkg::*;

    logic [63:0] rem_reg, quo_reg, md_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] shifted, diff;
    logic        ge;

    assign shifted  = {rem_reg, quo_reg[63]};
    assign diff     = shifted - {1'b0, md_reg};
    assign ge       = !diff[64];
    assign done     = done_reg;
    assign quotient = neg_reg ? (64'd0 - quo_reg) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 6'd63)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num[63] ? (64'd0 - num) : num;
            md_reg  <= den[63] ? (64'd0 - den) : den;
            neg_reg <= num[63] ^ den[63];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[63:0] : shifted[63:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

endmodule
`default_nettype wire

/* src/btpc_back.sv */
// Back end: sequences the compensation over the shared multiplier and divider
// and holds the result in the output register. Depends on btpc_pkg,
// btpc_mul and btpc_div.
`default_nettype none
module btpc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire btpc_pkg::trim_t       trim,
    input  wire logic                  head_valid,
    input  wire btpc_pkg::item_t       head,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [95:0]                m_tdata,
    output logic                       m_tuser
);
    import btpc_pkg::*;

    state_t      state_reg, state_next;
    op_t         step_reg, step_next;
    item_t       cur_reg;
    logic [63:0] tv1_reg, bb_reg, s1_reg, v2_reg, lin_reg, den_reg, p_reg;
    logic [31:0] tf_reg, pres_reg;
    logic        dz_reg;
    logic        out_valid_reg;
    logic [95:0] out_data_reg;
    logic        out_user_reg;

    logic        mul_start, mul_done, div_start, div_done, out_load;
    logic [63:0] mul_a, mul_b, mul_r, div_q;
    logic [63:0] v1c, ph, pn, den_new, tsum, psum, pfin;
    logic [31:0] t5, tc;

    btpc_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_r)
    );

    btpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (mul_r),
        .den      (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign v1c     = {{32{tf_reg[31]}}, tf_reg} - 64'd128000;
    assign ph      = asr64(p_reg, 13);
    assign pn      = ((64'd1048576 - {44'd0, cur_reg.raw_pressure}) << 31) - v2_reg;
    assign den_new = asr64(mul_r, 33);
    assign tsum    = tv1_reg + asr64(sx32(mul_r), 14);
    assign psum    = p_reg + lin_reg + asr64(mul_r, 19);
    assign pfin    = asr64(psum, 8) + (sx16(trim.p7) << 4);
    assign t5      = {tf_reg[29:0], 2'b00} + tf_reg + 32'd128;
    assign tc      = 32'($signed(t5) >>> 8);

    // multiplier operands per step
    always_comb
    begin
        case (step_reg)
            OP_TV1:
            begin
                mul_a = {{46{cur_reg.ta[17]}}, cur_reg.ta};
                mul_b = sx16(trim.t2);
            end
            OP_BB:
            begin
                mul_a = {{47{cur_reg.tb[16]}}, cur_reg.tb};
                mul_b = {{47{cur_reg.tb[16]}}, cur_reg.tb};
            end
            OP_TV2:
            begin
                mul_a = bb_reg;
                mul_b = sx16(trim.t3);
            end
            OP_S1:
            begin
                mul_a = v1c;
                mul_b = v1c;
            end
            OP_V2A:
            begin
                mul_a = s1_reg;
                mul_b = sx16(trim.p6);
            end
            OP_S2:
            begin
                mul_a = v1c;
                mul_b = sx16(trim.p5);
            end
            OP_S3:
            begin
                mul_a = s1_reg;
                mul_b = sx16(trim.p3);
            end
            OP_S4:
            begin
                mul_a = v1c;
                mul_b = sx16(trim.p2);
            end
            OP_S5:
            begin
                mul_a = lin_reg + 64'h0000_8000_0000_0000;
                mul_b = {48'd0, trim.p1};
            end
            OP_NUM:
            begin
                mul_a = pn;
                mul_b = 64'd3125;
            end
            OP_W1A:
            begin
                mul_a = sx16(trim.p9);
                mul_b = ph;
            end
            OP_W1B:
            begin
                mul_a = s1_reg;
                mul_b = ph;
            end
            OP_W2:
            begin
                mul_a = sx16(trim.p8);
                mul_b = p_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (step_reg)
            OP_TV1:  step_next = OP_BB;
            OP_BB:   step_next = OP_TV2;
            OP_TV2:  step_next = OP_S1;
            OP_S1:   step_next = OP_V2A;
            OP_V2A:  step_next = OP_S2;
            OP_S2:   step_next = OP_S3;
            OP_S3:   step_next = OP_S4;
            OP_S4:   step_next = OP_S5;
            OP_S5:   step_next = OP_NUM;
            OP_NUM:  step_next = OP_W1A;
            OP_W1A:  step_next = OP_W1B;
            OP_W1B:  step_next = OP_W2;
            default: step_next = OP_TV1;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (head_valid)
                    state_next = ST_ISSUE;
            ST_ISSUE:
                state_next = ST_MUL;
            ST_MUL:
                if (mul_done)
                begin
                    if (step_reg == OP_W2)
                        state_next = ST_OUT;
                    else if (step_reg == OP_S5 && den_new == '0)
                        state_next = ST_OUT;
                    else if (step_reg == OP_NUM)
                        state_next = ST_DIV;
                    else
                        state_next = ST_ISSUE;
                end
            ST_DIV:
                if (div_done)
                    state_next = ST_ISSUE;
            ST_OUT:
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop       = (state_reg == ST_IDLE) && head_valid;
        mul_start = (state_reg == ST_ISSUE);
        div_start = (state_reg == ST_MUL) && mul_done && (step_reg == OP_NUM);
        out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= OP_TV1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                step_reg <= OP_TV1;
            else if (state_reg == ST_MUL && mul_done)
                step_reg <= step_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
            dz_reg  <= 1'b0;
        end
        if (state_reg == ST_MUL && mul_done)
        begin
            case (step_reg)
                OP_TV1: tv1_reg <= asr64(sx32(mul_r), 11);
                OP_BB:  bb_reg  <= asr64(sx32(mul_r), 12);
                OP_TV2: tf_reg  <= tsum[31:0];
                OP_S1:  s1_reg  <= mul_r;
                OP_V2A: v2_reg  <= mul_r + (sx16(trim.p4) << 35);
                OP_S2:  v2_reg  <= v2_reg + (mul_r << 17);
                OP_S3:  lin_reg <= asr64(mul_r, 8);
                OP_S4:  lin_reg <= lin_reg + (mul_r << 12);
                OP_S5:
                begin
                    den_reg <= den_new;
                    // zero divisor: drop pressure, flag it
                    if (den_new == '0)
                    begin
                        dz_reg   <= 1'b1;
                        pres_reg <= '0;
                    end
                end
                OP_W1A: s1_reg   <= mul_r;
                OP_W1B: lin_reg  <= asr64(mul_r, 25);
                OP_W2:  pres_reg <= pfin[31:0];
                default: ;
            endcase
        end
        if (div_done)
            p_reg <= div_q;
        if (out_load)
        begin
            out_data_reg <= {pres_reg, tf_reg, tc};
            out_user_reg <= dz_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_mul_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_MUL)
        else $error("multiplier result arrived outside a multiply wait");

    a_div_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider result arrived outside a divide wait");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid)
        else $error("loaded result not presented");

    a_pop_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == ST_ISSUE && step_reg == OP_TV1)
        else $error("item pop did not start the sequence");

endmodule
`default_nettype wire

/* tb/baro_temp_pressure_compensator_core_tb.sv */
// Self-checking bench for the barometric trim compensator core.
// Predicts temperature and pressure compensation per item and checks each result;
// depends on btpc_pkg and the core RTL.
`timescale 1ns / 1ps
module baro_temp_pressure_compensator_core_tb;
    import btpc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;

    typedef struct packed {
        logic [31:0] temp_centi;
        logic [31:0] t_fine;
        logic [31:0] press;
        logic        div_zero;
    } comp_result_t;

    logic [47:0]  trim_regs [NumTrimReg];
    comp_result_t pending_results [$];
    int           error_count;
    int           hold_cycles;
    int           burst_left;

    baro_temp_pressure_compensator_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("baro_temp_pressure_compensator_core: mismatch");
        $finish;
    end

    function automatic logic signed [63:0] trim_field(input int r, input int k);
        logic [15:0] v;
        v = trim_regs[r][16*k +: 16];
        return {{48{v[15]}}, v};
    endfunction

    function automatic comp_result_t compensate(input logic [19:0] rawt,
                                                input logic [19:0] rawp);
        logic signed [31:0] t1, t2, t3, a, b, tv1, tv2, tfine, bb;
        logic signed [63:0] v1, v2, p1, pdiv, ph, w1, w2, num, q;
        logic [63:0]        mn, md;
        comp_result_t       r;
        t1 = {16'd0, trim_regs[0][15:0]};
        t2 = 32'(trim_field(0, 1));
        t3 = 32'(trim_field(0, 2));
        a = 32'(rawt >> 3) - (t1 <<< 1);
        tv1 = (a * t2) >>> 11;
        b = 32'(rawt >> 4) - t1;
        bb = (b * b) >>> 12;
        tv2 = (bb * t3) >>> 14;
        tfine = tv1 + tv2;
        r.temp_centi = (tfine * 5 + 128) >>> 8;
        r.t_fine = tfine;
        v1 = 64'(tfine) - 64'sd128000;
        v2 = v1 * v1 * trim_field(2, 2);
        v2 = v2 + ((v1 * trim_field(2, 1)) <<< 17);
        v2 = v2 + (trim_field(2, 0) <<< 35);
        p1 = {48'd0, trim_regs[1][15:0]};
        v1 = ((v1 * v1 * trim_field(1, 2)) >>> 8) + ((v1 * trim_field(1, 1)) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        r.press = '0;
        r.div_zero = (v1 == 0);
        if (v1 != 0)
        begin
            num = (((64'sd1048576 - 64'(rawp)) <<< 31) - v2) * 64'sd3125;
            // truncating divide on magnitudes; min / -1 wraps naturally
            mn = num[63] ? -num : num;
            md = v1[63] ? -v1 : v1;
            q = mn / md;
            pdiv = (num[63] != v1[63]) ? -q : q;
            ph = pdiv >>> 13;
            w1 = (trim_field(3, 2) * ph * ph) >>> 25;
            w2 = (trim_field(3, 1) * pdiv) >>> 19;
            pdiv = ((pdiv + w1 + w2) >>> 8) + (trim_field(3, 0) <<< 4);
            r.press = pdiv[31:0];
        end
        return r;
    endfunction

    // receiver: random stall pattern, long hold-off counted here
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        comp_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    $display("%0t: expected tc=%h tf=%h p=%h dz=%b got tc=%h tf=%h p=%h dz=%b",
                             $time, want.temp_centi, want.t_fine, want.press, want.div_zero,
                             got.temp_centi, got.t_fine, got.press, got.div_zero);
                if (got !== want)
                    error_count++;
            end
        end
    end

    // hold the item valid into the next call so bursts run back to back
    task automatic send_reading(input logic [19:0] rawt, input logic [19:0] rawp);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {rawp, rawt};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(compensate(rawt, rawp));
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_trim(input logic [1:0] idx, input logic [47:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        trim_regs[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // trim set near typical factory values, with random spread
    task automatic load_typical_trim();
        write_trim(REG_TEMP, {16'hFC18 + 16'($urandom_range(0, 40)),
                              16'd26000 + 16'($urandom_range(0, 2000)),
                              16'd27000 + 16'($urandom_range(0, 2000))});
        write_trim(REG_PRESS_A, {16'd3024, 16'hD6D0 + 16'($urandom_range(0, 200)),
                                 16'd36000 + 16'($urandom_range(0, 2000))});
        write_trim(REG_PRESS_B, {16'hFFF9, 16'd140 + 16'($urandom_range(0, 10)),
                                 16'($urandom_range(2000, 9000))});
        write_trim(REG_PRESS_C, {16'd6000 + 16'($urandom_range(0, 500)), 16'hC000, 16'd15500});
    endtask

    task automatic load_random_trim();
        for (int i = 0; i < NumTrimReg; i++)
            write_trim(i[1:0], 48'({$urandom, $urandom}));
    endtask

    task automatic test_reset_trim();
        // all trim zero: divisor vanishes
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        drain_results();
    endtask

    task automatic test_extreme_trim();
        for (int i = 0; i < NumTrimReg; i++)
            write_trim(i[1:0], 48'hFFFF_FFFF_FFFF);
        send_reading(20'd0, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'd0);
        drain_results();
        write_trim(REG_TEMP, 48'h8000_8000_FFFF);
        write_trim(REG_PRESS_A, 48'h7FFF_7FFF_FFFF);
        write_trim(REG_PRESS_B, 48'h8000_7FFF_8000);
        write_trim(REG_PRESS_C, 48'h7FFF_8000_7FFF);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'h55555, 20'hAAAAA);
        drain_results();
    endtask

    task automatic test_typical_readings();
        load_typical_trim();
        send_reading(20'd519888, 20'd415148);
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'hAAAAA, 20'h55555);
        // P1 zero forces zero divisor with real temperature
        drain_results();
        write_trim(REG_PRESS_A, 48'h0000_0000_0000);
        send_reading(20'd519888, 20'd415148);
        drain_results();
    endtask

    task automatic test_backpressure();
        load_typical_trim();
        hold_cycles = 2000;
        repeat (12) send_reading(20'($urandom), 20'($urandom));
        wait (hold_cycles == 0);
        drain_results();
    endtask

    task automatic test_random_readings();
        for (int phase = 0; phase < 18; phase++)
        begin
            if (phase % 3 == 2)
                load_random_trim();
            else
                load_typical_trim();
            repeat (100)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_reading(20'($urandom), 20'($urandom));
                else
                    send_reading(20'($urandom_range(380000, 620000)),
                                 20'($urandom_range(200000, 500000)));
            end
            drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_cycles = 0;
        burst_left = 0;
        error_count = 0;
        for (int i = 0; i < NumTrimReg; i++)
            trim_regs[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(posedge clk);
        test_reset_trim();
        test_extreme_trim();
        test_typical_readings();
        test_backpressure();
        test_random_readings();
        drain_results();
        if (error_count == 0)
            $display("baro_temp_pressure_compensator_core: match");
        else
            $display("baro_temp_pressure_compensator_core: mismatch");
        $finish;
    end
endmodule
